// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge outside reset
`define SSC_ASSERT(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define SSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SSC_ASSERT(label, clk, rst, cond, msg)
`define SSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/ssc_pkg.sv -----
// Shared types and constants for the subsampled span coverage block.
package ssc_pkg;

  // Default subsampling factor per axis
  localparam int SUB_SAMPLES_DEF = 8;

  // Field widths
  localparam int EDGE_W  = 21;
  localparam int SLOT_W  = 3;
  localparam int COL_W   = 16;
  localparam int ALPHA_W = 8;

  // Position arithmetic: edges plus column window without overflow
  localparam int POS_W = EDGE_W + 2;

  // Full-scale alpha
  localparam int ALPHA_MAX = 255;

  // Item operation codes
  typedef enum logic [0:0] {
    OP_SPAN  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  // Pixel item held in the input register
  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [ALPHA_W-1:0] dest;
  } pixel_t;

endpackage

// ----- hw/rtl/ssc_span_store.sv -----
// Subrow span slots: edges and valid bits written by span transfers.
module ssc_span_store #(
  parameter int SUB_SAMPLES = ssc_pkg::SUB_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic [ssc_pkg::SLOT_W-1:0]        sub_row,
  input  logic signed [ssc_pkg::EDGE_W-1:0] span_left,
  input  logic signed [ssc_pkg::EDGE_W-1:0] span_right,
  input  logic                              span_present,
  output logic signed [ssc_pkg::EDGE_W-1:0] left_edges  [SUB_SAMPLES],
  output logic signed [ssc_pkg::EDGE_W-1:0] right_edges [SUB_SAMPLES],
  output logic [SUB_SAMPLES-1:0]            row_valid
);
  import ssc_pkg::*;

  // Valid bits; a slot number beyond the subsampling matches no slot
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else begin
      for (int k = 0; k < SUB_SAMPLES; k++) begin
        if (we && int'(sub_row) == k) begin
          row_valid[k] <= span_present;
        end
      end
    end
  end

  // Edge storage, only meaningful while the slot is valid
  always_ff @(posedge clk) begin
    for (int k = 0; k < SUB_SAMPLES; k++) begin
      if (we && int'(sub_row) == k) begin
        left_edges[k]  <= span_left;
        right_edges[k] <= span_right;
      end
    end
  end

endmodule

// ----- hw/rtl/ssc_overlap_stage.sv -----
// Per-slot overlap of each span with the pixel's subsample window, registered.
module ssc_overlap_stage #(
  parameter  int SUB_SAMPLES = ssc_pkg::SUB_SAMPLES_DEF,
  localparam int OVL_W       = $clog2(SUB_SAMPLES + 1)
) (
  input  logic                              clk,
  input  logic                              load,
  input  ssc_pkg::pixel_t                   pixel,
  input  logic signed [ssc_pkg::EDGE_W-1:0] left_edges  [SUB_SAMPLES],
  input  logic signed [ssc_pkg::EDGE_W-1:0] right_edges [SUB_SAMPLES],
  input  logic [SUB_SAMPLES-1:0]            row_valid,
  output logic [OVL_W-1:0]                  ovl [SUB_SAMPLES],
  output logic [ssc_pkg::ALPHA_W-1:0]       dest
);
  import ssc_pkg::*;

  logic [POS_W-1:0]        win_lo_u;
  logic [POS_W-1:0]        win_hi_u;
  logic signed [POS_W-1:0] win_lo;
  logic signed [POS_W-1:0] win_hi;
  logic signed [POS_W-1:0] edge_l [SUB_SAMPLES];
  logic signed [POS_W-1:0] edge_r [SUB_SAMPLES];
  logic signed [POS_W-1:0] cut_lo [SUB_SAMPLES];
  logic signed [POS_W-1:0] cut_hi [SUB_SAMPLES];
  logic signed [POS_W-1:0] cut_len [SUB_SAMPLES];
  logic [OVL_W-1:0]        ovl_next [SUB_SAMPLES];

  // Subsample window of the column: [col*S, col*S + S)
  always_comb begin
    win_lo_u = POS_W'(pixel.col) * POS_W'(SUB_SAMPLES);
    win_hi_u = win_lo_u + POS_W'(SUB_SAMPLES);
    win_lo   = signed'(win_lo_u);
    win_hi   = signed'(win_hi_u);
  end

  // Clip every slot against the window in parallel
  always_comb begin
    for (int k = 0; k < SUB_SAMPLES; k++) begin
      edge_l[k]  = POS_W'(left_edges[k]);
      edge_r[k]  = POS_W'(right_edges[k]);
      cut_lo[k]  = (edge_l[k] > win_lo) ? edge_l[k] : win_lo;
      cut_hi[k]  = (edge_r[k] < win_hi) ? edge_r[k] : win_hi;
      cut_len[k] = cut_hi[k] - cut_lo[k];
      // reversed or absent spans add nothing
      if (row_valid[k] && (edge_l[k] <= edge_r[k]) && (cut_hi[k] > cut_lo[k])) begin
        ovl_next[k] = cut_len[k][OVL_W-1:0];
      end else begin
        ovl_next[k] = '0;
      end
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (load) begin
      ovl  <= ovl_next;
      dest <= pixel.dest;
    end
  end

endmodule

// ----- hw/rtl/ssc_resolve_stage.sv -----
// Sums slot overlaps, scales to alpha through a constant table, keeps the maximum.
module ssc_resolve_stage #(
  parameter  int SUB_SAMPLES = ssc_pkg::SUB_SAMPLES_DEF,
  localparam int OVL_W       = $clog2(SUB_SAMPLES + 1)
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic [OVL_W-1:0]            ovl [SUB_SAMPLES],
  input  logic [ssc_pkg::ALPHA_W-1:0] dest,
  output logic [ssc_pkg::ALPHA_W-1:0] pixel_alpha
);
  import ssc_pkg::*;

  localparam int CovDen = SUB_SAMPLES * SUB_SAMPLES;
  localparam int SUM_W  = $clog2(CovDen + 1);

  logic [SUM_W-1:0]   cov_sum;
  logic [ALPHA_W-1:0] cov;
  logic [ALPHA_W-1:0] alpha_next;
  logic [ALPHA_W-1:0] cov_lut [CovDen + 1];

  // Scaling table: sum * 255 / (S*S), truncated
  for (genvar i = 0; i <= CovDen; i++) begin : g_lut
    localparam int Q = (i * ALPHA_MAX) / CovDen;
    assign cov_lut[i] = ALPHA_W'(Q);
  end

  // Coverage count over all slots
  always_comb begin
    cov_sum = '0;
    for (int k = 0; k < SUB_SAMPLES; k++) begin
      cov_sum = cov_sum + SUM_W'(ovl[k]);
    end
  end

  // Scale and merge with the existing alpha
  always_comb begin
    cov        = cov_lut[cov_sum];
    alpha_next = (cov > dest) ? cov : dest;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      pixel_alpha <= alpha_next;
    end
  end

endmodule

// ----- hw/rtl/subsampled_span_coverage.sv -----
// Anti-aliased span coverage for one pixel row, SUB_SAMPLES x SUB_SAMPLES subsampling.
// A pixel result passes the input, overlap and result registers in that order.
// Throughput: one item per cycle unless the result is stalled; span transfers update the slots and give no result.
// A span takes effect for every pixel transferred after it; the slot registers set this.
// Reset (synchronous, active high) empties the pipeline and clears all slot valid bits.
`include "assert_macros.svh"

module subsampled_span_coverage #(
  parameter int SUB_SAMPLES = ssc_pkg::SUB_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic                              operation,
  input  logic [ssc_pkg::SLOT_W-1:0]        sub_row,
  input  logic signed [ssc_pkg::EDGE_W-1:0] span_left,
  input  logic signed [ssc_pkg::EDGE_W-1:0] span_right,
  input  logic                              span_present,
  input  logic [ssc_pkg::COL_W-1:0]         pixel_column,
  input  logic [ssc_pkg::ALPHA_W-1:0]       dest_alpha,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [ssc_pkg::ALPHA_W-1:0]       pixel_alpha
);
  import ssc_pkg::*;

  localparam int OVL_W = $clog2(SUB_SAMPLES + 1);

  logic                     item_take;
  logic                     span_we;
  logic                     pixel_take;
  logic                     s1_valid;
  logic                     s2_valid;
  logic                     s2_free;
  logic                     s3_free;
  pixel_t                   s1_pixel;
  logic [OVL_W-1:0]         s2_ovl [SUB_SAMPLES];
  logic [ALPHA_W-1:0]       s2_dest;
  logic signed [EDGE_W-1:0] left_edges  [SUB_SAMPLES];
  logic signed [EDGE_W-1:0] right_edges [SUB_SAMPLES];
  logic [SUB_SAMPLES-1:0]   row_valid;

  // Handshake and stage advance; the input register only holds when stage 2 is blocked,
  // so slots never change under a waiting pixel
  assign s3_free    = !result_valid || result_ready;
  assign s2_free    = !s2_valid || s3_free;
  assign item_ready = !s1_valid || s2_free;
  assign item_take  = item_valid && item_ready;
  assign span_we    = item_take && (operation == OP_SPAN);
  assign pixel_take = item_take && (operation == OP_PIXEL);

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= pixel_take;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        result_valid <= s2_valid;
      end
    end
  end

  // Input register for pixel items
  always_ff @(posedge clk) begin
    if (pixel_take) begin
      s1_pixel.col  <= pixel_column;
      s1_pixel.dest <= dest_alpha;
    end
  end

  ssc_span_store #(
    .SUB_SAMPLES (SUB_SAMPLES)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .we           (span_we),
    .sub_row      (sub_row),
    .span_left    (span_left),
    .span_right   (span_right),
    .span_present (span_present),
    .left_edges   (left_edges),
    .right_edges  (right_edges),
    .row_valid    (row_valid)
  );

  ssc_overlap_stage #(
    .SUB_SAMPLES (SUB_SAMPLES)
  ) u_overlap (
    .clk         (clk),
    .load        (s1_valid && s2_free),
    .pixel       (s1_pixel),
    .left_edges  (left_edges),
    .right_edges (right_edges),
    .row_valid   (row_valid),
    .ovl         (s2_ovl),
    .dest        (s2_dest)
  );

  ssc_resolve_stage #(
    .SUB_SAMPLES (SUB_SAMPLES)
  ) u_resolve (
    .clk         (clk),
    .load        (s2_valid && s3_free),
    .ovl         (s2_ovl),
    .dest        (s2_dest),
    .pixel_alpha (pixel_alpha)
  );

  // Checks on pipeline control
  `SSC_ASSERT(a_stall_only_when_full, clk, rst, item_ready || (s1_valid && s2_valid), "input stalled with a free stage")
  `SSC_ASSERT_NEXT(a_pixel_enters, clk, rst, pixel_take, s1_valid, "pixel transfer lost at input register")
  `SSC_ASSERT_NEXT(a_span_no_entry, clk, rst, span_we && !s1_valid, !s1_valid, "span transfer entered the pipeline")
  `SSC_ASSERT_NEXT(a_alpha_not_below, clk, rst, s2_valid && s3_free, result_valid && (pixel_alpha >= $past(s2_dest)), "result below existing alpha")

endmodule
